// ===== hw/rtl/ssir_pkg.sv =====
// Shared codes, widths and cell command type for the sorted set block.
`default_nettype none

package ssir_pkg;

    // Fixed field widths
    localparam int VALUE_W  = 32;
    localparam int OP_W     = 2;
    localparam int INDEX_W  = 5;
    localparam int STATUS_W = 3;

    // Default number of entries in the chain
    localparam int CAPACITY_DEF = 32;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_READ      = 3'd5;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic                      insert_en;
        logic                      remove_en;
        logic signed [VALUE_W-1:0] value;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ssir_cell.sv =====
// One storage cell of the sorted chain: compare against the key and shift.
`default_nettype none

module ssir_cell (
    input  wire logic                               clk,
    input  wire ssir_pkg::cell_cmd_t                cmd,
    input  wire logic                               live,
    input  wire logic                               left_less,
    input  wire logic signed [ssir_pkg::VALUE_W-1:0] left_entry,
    input  wire logic signed [ssir_pkg::VALUE_W-1:0] right_entry,
    output logic signed [ssir_pkg::VALUE_W-1:0]      entry,
    output logic                                    less,
    output logic                                    match
);

    logic signed [ssir_pkg::VALUE_W-1:0] entry_reg;
    logic signed [ssir_pkg::VALUE_W-1:0] entry_next;

    // Compare the held entry against the broadcast key
    assign less  = live && (entry_reg < cmd.value);
    assign match = live && (entry_reg == cmd.value);
    assign entry = entry_reg;

    // Cells at or above the key position take the key, or shift up or down
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.insert_en && !less)
        begin
            entry_next = left_less ? cmd.value : left_entry;
        end
        else if (cmd.remove_en && !less)
        begin
            entry_next = right_entry;
        end
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_set_insert_remove.sv =====
// Top level of the sorted set: a chain of compare-and-shift cells plus result logic.
//
// Usage: raise start for one cycle with op, value and index; the item transfers
// at the rising edge where start is high and busy is low. busy stays low, so a
// new command may follow in every cycle.
// op insert places value at its ascending position, moving larger entries up;
// op remove deletes a present value and closes the gap; the other two op codes
// read: they return the entry at index in ascending order, or zero past count.
// The result appears in the cycle after the transfer, on status, count and
// read_value, marked by done for exactly one cycle. Throughput: one command per
// cycle, set by the compare and shift that every cell of the chain does at once.
// The receiver cannot stall; done is a strobe; results hold until the next transfer.
// Reset (rst_n low, asynchronous) empties the set: count returns to zero and no
// result is pending. Stored entries are not cleared; only entries below count
// are ever read.
`default_nettype none

module sorted_set_insert_remove #(
    parameter int CAPACITY = ssir_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [ssir_pkg::OP_W-1:0]          op,
    input  wire logic signed [ssir_pkg::VALUE_W-1:0] value,
    input  wire logic [ssir_pkg::INDEX_W-1:0]       index,
    output logic                                    done,
    output logic [ssir_pkg::STATUS_W-1:0]           status,
    output logic [CNT_W-1:0]                        count,
    output logic signed [ssir_pkg::VALUE_W-1:0]     read_value
);

    localparam int RD_N = (CAPACITY < (1 << ssir_pkg::INDEX_W)) ?
                          CAPACITY : (1 << ssir_pkg::INDEX_W);

    logic                                   accept;
    logic                                   present;
    logic                                   full;
    ssir_pkg::cell_cmd_t                    cmd;
    logic signed [ssir_pkg::VALUE_W-1:0]    entry_w [CAPACITY];
    logic [CAPACITY-1:0]                    less_w;
    logic [CAPACITY-1:0]                    match_w;
    logic [CAPACITY-1:0]                    live_w;
    logic signed [ssir_pkg::VALUE_W-1:0]    rd_sel;

    logic [CNT_W-1:0]                       count_reg;
    logic [CNT_W-1:0]                       count_next;
    logic                                   done_reg;
    logic [ssir_pkg::STATUS_W-1:0]          status_reg;
    logic [ssir_pkg::STATUS_W-1:0]          status_next;
    logic signed [ssir_pkg::VALUE_W-1:0]    read_value_reg;
    logic signed [ssir_pkg::VALUE_W-1:0]    read_value_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(CAPACITY));

    // Cells below the count hold live entries
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_live
            assign live_w[gi] = (CNT_W'(gi) < count_reg);
        end
    endgenerate

    // Search result of the whole chain
    assign present = |match_w;

    // Broadcast command to the cells
    always_comb
    begin
        cmd.value     = value;
        cmd.insert_en = accept && (op == ssir_pkg::OP_INSERT) && !present && !full;
        cmd.remove_en = accept && (op == ssir_pkg::OP_REMOVE) && present;
    end

    // Chain of cells linked to neighbors; the ends take value and their own entry
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                                left_less_w;
            logic signed [ssir_pkg::VALUE_W-1:0] left_entry_w;
            logic signed [ssir_pkg::VALUE_W-1:0] right_entry_w;

            if (gi == 0)
            begin : g_first
                assign left_less_w  = 1'b1;
                assign left_entry_w = value;
            end
            else
            begin : g_inner
                assign left_less_w  = less_w[gi-1];
                assign left_entry_w = entry_w[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_entry_w = entry_w[gi];
            end
            else
            begin : g_mid
                assign right_entry_w = entry_w[gi+1];
            end

            ssir_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .live        (live_w[gi]),
                .left_less   (left_less_w),
                .left_entry  (left_entry_w),
                .right_entry (right_entry_w),
                .entry       (entry_w[gi]),
                .less        (less_w[gi]),
                .match       (match_w[gi])
            );
        end
    endgenerate

    // Select the live entry at the read index
    always_comb
    begin
        rd_sel = '0;
        for (int i = 0; i < RD_N; i++)
        begin
            if ((ssir_pkg::INDEX_W'(i) == index) && live_w[i])
            begin
                rd_sel = rd_sel | entry_w[i];
            end
        end
    end

    // Decide status, new count and read data
    always_comb
    begin
        count_next      = count_reg;
        read_value_next = '0;
        unique case (op)
            ssir_pkg::OP_INSERT:
            begin
                if (present)
                begin
                    status_next = ssir_pkg::ST_DUPLICATE;
                end
                else if (full)
                begin
                    status_next = ssir_pkg::ST_FULL;
                end
                else
                begin
                    status_next = ssir_pkg::ST_INSERTED;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            ssir_pkg::OP_REMOVE:
            begin
                if (present)
                begin
                    status_next = ssir_pkg::ST_REMOVED;
                    count_next  = count_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = ssir_pkg::ST_NOTFOUND;
                end
            end
            default:
            begin
                status_next     = ssir_pkg::ST_READ;
                read_value_next = rd_sel;
            end
        endcase
    end

    // Hold count and control; advance on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Capture result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg     <= status_next;
            read_value_reg <= read_value_next;
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign count      = count_reg;
    assign read_value = read_value_reg;

    // Count never exceeds the chain length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count exceeds capacity");

    // Every transfer yields a result in the next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done_reg)
        else $error("missing result strobe");

    // No result without a transfer
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done_reg)
        else $error("spurious result strobe");

    // A successful insert grows the set by one
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (status_reg == ssir_pkg::ST_INSERTED)
        |-> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow count");

    // Only reads return data
    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (status_reg != ssir_pkg::ST_READ) |-> read_value_reg == '0)
        else $error("nonzero read_value on non-read result");

endmodule

`default_nettype wire
